/* rtl/core/shortest_job_first_scheduler_assert.svh */
// Assertion macros for the shortest job first scheduler.
// Included by the top level; expects a clock named clk and reset named rst.
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_ASSERT_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define SJFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SJFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sjfs_pkg.sv */
// Shared types and constants for the shortest job first scheduler.
// No dependencies.
package sjfs_pkg;

  localparam int MAX_JOBS_DEF  = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam int ID_W       = 8;
  localparam int IN_TIME_W  = 16;
  localparam int OUT_TIME_W = 23;
  localparam int IN_W       = ID_W + 2 * IN_TIME_W;
  localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W      = ID_W + 3 * OUT_TIME_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic clear;
    logic valid;
    logic mode;
  } sel_ctrl_t;

  typedef struct packed {
    logic sjf_found;
    logic early_found;
  } sel_stat_t;

endpackage

/* rtl/core/sjfs_sel.sv */
// Running selection of the next job over one table scan.
// Depends on sjfs_pkg.
module sjfs_sel #(
  parameter int TIME_BITS = sjfs_pkg::TIME_BITS_DEF,
  parameter int IDX_W     = 6,
  parameter int CT_W      = 23
) (
  input  logic                    clk,
  input  logic                    rst,
  input  sjfs_pkg::sel_ctrl_t     ctrl,
  input  logic [sjfs_pkg::ID_W-1:0] e_id,
  input  logic [TIME_BITS-1:0]    e_arr,
  input  logic [TIME_BITS-1:0]    e_bur,
  input  logic [IDX_W-1:0]        e_idx,
  input  logic [CT_W-1:0]         cur_time,
  output logic [sjfs_pkg::ID_W-1:0] p_id,
  output logic [TIME_BITS-1:0]    p_arr,
  output logic [TIME_BITS-1:0]    p_bur,
  output logic [IDX_W-1:0]        p_idx,
  output sjfs_pkg::sel_stat_t     st
);

  logic [sjfs_pkg::ID_W-1:0] sb_id, eb_id;
  logic [TIME_BITS-1:0]      sb_arr, sb_bur, eb_arr, eb_bur;
  logic [IDX_W-1:0]          sb_idx, eb_idx;
  logic                      sjf_found, early_found;
  logic                      arrived, sjf_lt, early_lt, use_sjf;

  assign arrived = CT_W'(e_arr) <= cur_time;

  assign sjf_lt = (e_bur < sb_bur) ||
                  (e_bur == sb_bur && ((e_arr < sb_arr) ||
                                       (e_arr == sb_arr && e_id < sb_id)));

  // earliest arrival; in SJF mode the burst breaks ties before the id
  assign early_lt = (e_arr < eb_arr) ||
                    (e_arr == eb_arr && ((ctrl.mode && e_bur < eb_bur) ||
                     ((!ctrl.mode || e_bur == eb_bur) && e_id < eb_id)));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sjf_found   <= 1'b0;
      early_found <= 1'b0;
    end else if (ctrl.valid) begin
      if (arrived && (!sjf_found || sjf_lt)) sjf_found <= 1'b1;
      if (!early_found || early_lt) early_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid && !ctrl.clear) begin
      if (arrived && (!sjf_found || sjf_lt)) begin
        sb_id  <= e_id;
        sb_arr <= e_arr;
        sb_bur <= e_bur;
        sb_idx <= e_idx;
      end
      if (!early_found || early_lt) begin
        eb_id  <= e_id;
        eb_arr <= e_arr;
        eb_bur <= e_bur;
        eb_idx <= e_idx;
      end
    end
  end

  assign use_sjf = ctrl.mode && sjf_found;
  assign p_id    = use_sjf ? sb_id  : eb_id;
  assign p_arr   = use_sjf ? sb_arr : eb_arr;
  assign p_bur   = use_sjf ? sb_bur : eb_bur;
  assign p_idx   = use_sjf ? sb_idx : eb_idx;

  assign st.sjf_found   = sjf_found;
  assign st.early_found = early_found;

endmodule

/* rtl/core/shortest_job_first_scheduler.sv */
// Top level of the non-preemptive SJF / FCFS scheduler: job table memory,
// scan sequencer, timing arithmetic and output register.
// Depends on sjfs_pkg, sjfs_sel and shortest_job_first_scheduler_assert.svh.
//
//   channel   dir   content
//   s_*       in    one job per beat, tlast closes the set
//   m_*       out   one scheduled job per beat, tlast on the final one
//   cfg_*     in    policy_mode, 0 FCFS, 1 SJF
//
// Loading takes one beat per cycle while the sequencer is idle. Each
// scheduled job costs a scan of the table (one memory read per cycle)
// plus a pick step and an output step.
// Reset is synchronous; the table holds no reset value and needs no sweep.
// A stalled output holds the sequencer in its output step; loading waits
// until the whole set has been handed to the output register.
module shortest_job_first_scheduler #(
  parameter int MAX_JOBS  = sjfs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = sjfs_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sjfs_pkg::IN_TDATA_W-1:0]  s_tdata,  // job_id, job_arrival, job_burst
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_id, completion_time, turnaround_time, waiting_time, zero pad
  output logic [sjfs_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int CT_W  = TIME_BITS + $clog2(MAX_JOBS + 1);
  localparam int ENT_W = sjfs_pkg::ID_W + 2 * TIME_BITS;
  localparam int IW    = sjfs_pkg::ID_W;
  localparam int TW    = sjfs_pkg::IN_TIME_W;
  localparam int OTW   = sjfs_pkg::OUT_TIME_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PICK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count, remaining, ptr;
  logic [IDX_W-1:0]    ridx;
  logic                rv;
  logic [MAX_JOBS-1:0] done;
  logic [CT_W-1:0]     cur, start;
  logic                policy, mode;
  logic [ENT_W-1:0]    mem [MAX_JOBS];
  logic [ENT_W-1:0]    rdata;

  logic                accept, wr_en, issuing, scan_end, emit_go;
  logic [ENT_W-1:0]    wr_data;
  logic [CT_W-1:0]     fin, wt, tat;

  sjfs_pkg::sel_ctrl_t sel_ctrl;
  sjfs_pkg::sel_stat_t sel_st;
  logic [IW-1:0]        p_id;
  logic [TIME_BITS-1:0] p_arr, p_bur;
  logic [IDX_W-1:0]     p_idx;

  logic [IW-1:0]  out_id;
  logic [OTW-1:0] out_comp, out_tat, out_wait;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && (count < CNT_W'(MAX_JOBS));
  assign wr_data   = {TIME_BITS'(s_tdata[IW+2*TW-1:IW+TW]),
                      TIME_BITS'(s_tdata[IW+TW-1:IW]),
                      s_tdata[IW-1:0]};

  // table writes happen only while loading; read data is used only while scanning
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IDX_W-1:0]] <= wr_data;
    rdata <= mem[ptr[IDX_W-1:0]];
  end

  assign issuing  = (state == ST_SCAN) && (ptr < count);
  assign scan_end = rv && (CNT_W'(ridx) == count - CNT_W'(1));
  assign emit_go  = (state == ST_EMIT) && (!m_tvalid || m_tready);

  assign sel_ctrl.clear = (state == ST_SCAN) && (ptr == '0);
  assign sel_ctrl.valid = rv && !done[ridx];
  assign sel_ctrl.mode  = mode;

  sjfs_sel #(
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W),
    .CT_W      (CT_W)
  ) u_sel (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sel_ctrl),
    .e_id     (rdata[IW-1:0]),
    .e_arr    (rdata[IW+TIME_BITS-1:IW]),
    .e_bur    (rdata[ENT_W-1:IW+TIME_BITS]),
    .e_idx    (ridx),
    .cur_time (cur),
    .p_id     (p_id),
    .p_arr    (p_arr),
    .p_bur    (p_bur),
    .p_idx    (p_idx),
    .st       (sel_st)
  );

  assign fin = start + CT_W'(p_bur);
  assign wt  = start - CT_W'(p_arr);
  assign tat = wt + CT_W'(p_bur);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      ptr       <= '0;
      ridx      <= '0;
      rv        <= 1'b0;
      done      <= '0;
      cur       <= '0;
      policy    <= 1'b0;
      mode      <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) policy <= cfg_data;
      if (m_tvalid && m_tready && !emit_go) m_tvalid <= 1'b0;
      rv   <= issuing;
      ridx <= ptr[IDX_W-1:0];
      if (issuing) ptr <= ptr + CNT_W'(1);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (wr_en) count <= count + CNT_W'(1);
            if (s_tlast) begin
              remaining <= wr_en ? count + CNT_W'(1) : count;
              mode      <= policy;
              cur       <= '0;
              ptr       <= '0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) state <= ST_PICK;
        end
        ST_PICK: begin
          start <= (CT_W'(p_arr) > cur) ? CT_W'(p_arr) : cur;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_tvalid    <= 1'b1;
            m_tlast     <= (remaining == CNT_W'(1));
            remaining   <= remaining - CNT_W'(1);
            ptr         <= '0;
            if (remaining == CNT_W'(1)) begin
              done  <= '0;
              count <= '0;
              cur   <= '0;
              state <= ST_IDLE;
            end else begin
              cur         <= fin;
              done[p_idx] <= 1'b1;
              state       <= ST_SCAN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_id   <= p_id;
      out_comp <= OTW'(fin);
      out_tat  <= OTW'(tat);
      out_wait <= OTW'(wt);
    end
  end

  assign m_tdata = sjfs_pkg::OUT_TDATA_W'({out_wait, out_tat, out_comp, out_id});

`include "shortest_job_first_scheduler_assert.svh"

  `SJFS_ASSERT_NOW(a_busy_has_work, state != ST_IDLE, remaining != '0, "no jobs left while busy")
  `SJFS_ASSERT_NOW(a_pick_found, state == ST_PICK, sel_st.early_found && !done[p_idx], "pick without a pending job")
  `SJFS_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_JOBS), "job count past table depth")
  `SJFS_ASSERT_NEXT(a_set_closed, emit_go && remaining == CNT_W'(1), state == ST_IDLE && done == '0 && count == '0, "set not closed after final job")

endmodule

/* tb/sv/shortest_job_first_scheduler_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for shortest_job_first_scheduler, FCFS and SJF policies.
// Streams job sets in, predicts each schedule in a scoreboard class and checks
// every output beat field by field. Depends on sjfs_pkg and the scheduler RTL.
module shortest_job_first_scheduler_tb;

  localparam int ID_W        = sjfs_pkg::ID_W;
  localparam int IN_TIME_W   = sjfs_pkg::IN_TIME_W;
  localparam int OUT_TIME_W  = sjfs_pkg::OUT_TIME_W;
  localparam int IN_TDATA_W  = sjfs_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = sjfs_pkg::OUT_TDATA_W;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TABLE_DEPTH = sjfs_pkg::MAX_JOBS_DEF;
  localparam int HOLD_CYCLES = 1500;
  localparam int COMP_LSB    = ID_W;
  localparam int TAT_LSB     = ID_W + OUT_TIME_W;
  localparam int WAIT_LSB    = ID_W + 2 * OUT_TIME_W;

  typedef struct {
    logic [ID_W-1:0]      id;
    logic [IN_TIME_W-1:0] arrival;
    logic [IN_TIME_W-1:0] burst;
  } job_t;

  typedef struct {
    logic [ID_W-1:0]       id;
    logic [OUT_TIME_W-1:0] completion;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [OUT_TIME_W-1:0] waiting;
    logic                  last;
  } sched_t;

  class sjf_scoreboard;
    job_t   loaded_jobs[$];
    sched_t schedule_q[$];
    bit     sjf_mode;
    int     errors;
    int     jobs_loaded;
    int     sets_scheduled;
    int     results_checked;

    function void set_policy(bit mode);
      sjf_mode = mode;
    endfunction

    // store one job; the set-closing job yields the whole schedule
    function void note_job(job_t j, bit last);
      bit              done[];
      longint unsigned now, earliest, start, finish, tat, wt;
      int              best, n;
      bit              ready;
      sched_t          r;
      jobs_loaded++;
      if (loaded_jobs.size() < TABLE_DEPTH) loaded_jobs.push_back(j);
      if (!last) return;
      n = loaded_jobs.size();
      done = new[n];
      now = 0;
      for (int k = 0; k < n; k++) begin
        best = -1;
        if (sjf_mode) begin
          ready = 0;
          earliest = '1;
          for (int i = 0; i < n; i++) begin
            if (!done[i]) begin
              if (loaded_jobs[i].arrival <= now) ready = 1;
              if (loaded_jobs[i].arrival < earliest) earliest = loaded_jobs[i].arrival;
            end
          end
          // nothing ready: idle until the earliest remaining arrival
          if (!ready) now = earliest;
          for (int i = 0; i < n; i++) begin
            if (!done[i] && loaded_jobs[i].arrival <= now &&
                (best < 0 ||
                 {loaded_jobs[i].burst, loaded_jobs[i].arrival, loaded_jobs[i].id} <
                 {loaded_jobs[best].burst, loaded_jobs[best].arrival, loaded_jobs[best].id}))
              best = i;
          end
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!done[i] &&
                (best < 0 ||
                 {loaded_jobs[i].arrival, loaded_jobs[i].id} <
                 {loaded_jobs[best].arrival, loaded_jobs[best].id}))
              best = i;
          end
        end
        start  = (loaded_jobs[best].arrival > now) ? loaded_jobs[best].arrival : now;
        finish = start + loaded_jobs[best].burst;
        tat    = finish - loaded_jobs[best].arrival;
        wt     = tat - loaded_jobs[best].burst;
        done[best] = 1;
        now = finish;
        r.id         = loaded_jobs[best].id;
        r.completion = finish[OUT_TIME_W-1:0];
        r.turnaround = tat[OUT_TIME_W-1:0];
        r.waiting    = wt[OUT_TIME_W-1:0];
        r.last       = (k == n - 1);
        schedule_q.push_back(r);
      end
      loaded_jobs.delete();
      sets_scheduled++;
    endfunction

    function void compare_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0d, actual %0d", name, expected, actual);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      sched_t e;
      if (schedule_q.size() == 0) begin
        $error("output beat with no job scheduled, tdata %h", data);
        errors++;
        return;
      end
      e = schedule_q.pop_front();
      results_checked++;
      compare_field("out_id", 32'(e.id), 32'(data[ID_W-1:0]));
      compare_field("completion_time", 32'(e.completion),
                    32'(data[COMP_LSB +: OUT_TIME_W]));
      compare_field("turnaround_time", 32'(e.turnaround),
                    32'(data[TAT_LSB +: OUT_TIME_W]));
      compare_field("waiting_time", 32'(e.waiting), 32'(data[WAIT_LSB +: OUT_TIME_W]));
      compare_field("last_result", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // job_id, job_arrival, job_burst
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // out_id, completion, turnaround, waiting, pad
  logic                   m_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;

  sjf_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;
  int phase_items;
  int cycle_count;

  shortest_job_first_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_job(input logic [ID_W-1:0] id, input logic [IN_TIME_W-1:0] arrival,
                          input logic [IN_TIME_W-1:0] burst, input bit last);
    job_t j;
    j.id      = id;
    j.arrival = arrival;
    j.burst   = burst;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {burst, arrival, id};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_job(j, last);
    phase_items++;
  endtask

  // narrow sets crowd arrivals and bursts so ties and waiting are common
  task automatic send_random_set(input int n);
    bit narrow;
    narrow = ($urandom_range(3) != 0);
    for (int i = 0; i < n; i++) begin
      if (narrow)
        send_job(ID_W'($urandom_range(15)), IN_TIME_W'($urandom_range(300)),
                 IN_TIME_W'($urandom_range(40)), i == n - 1);
      else
        send_job(ID_W'($urandom), IN_TIME_W'($urandom), IN_TIME_W'($urandom), i == n - 1);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.schedule_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_policy(input bit mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_policy(mode);
  endtask

  // output side: check each beat, stall at random or during a long hold
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycle_count, sb.schedule_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sb = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 0;
    phase_items  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // FCFS: extremes, zero burst, equal arrival ties by id and by load order
    write_policy(1'b0);
    send_job(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_job(8'h00, 16'h0000, 16'h0000, 1'b0);
    send_job(8'd7, 16'd0, 16'd5, 1'b0);
    send_job(8'd7, 16'd0, 16'd5, 1'b1);
    drain();

    // SJF: idle start, burst ties by arrival then id, late and zero bursts
    write_policy(1'b1);
    send_job(8'd3, 16'd100, 16'd50, 1'b0);
    send_job(8'd1, 16'd100, 16'd50, 1'b0);
    send_job(8'd2, 16'd90, 16'd60, 1'b0);
    send_job(8'd8, 16'd95, 16'd50, 1'b0);
    send_job(8'd4, 16'd120, 16'd10, 1'b0);
    send_job(8'd9, 16'd120, 16'd10, 1'b0);
    send_job(8'd5, 16'hFFFF, 16'd0, 1'b0);
    send_job(8'd6, 16'd400, 16'd0, 1'b0);
    send_job(8'd10, 16'd30000, 16'd7, 1'b1);
    send_job(8'hAA, 16'h5555, 16'hAAAA, 1'b1);
    send_job(8'h55, 16'hAAAA, 16'h5555, 1'b1);

    // long output hold backs up the input; second set overflows the table
    hold_left = HOLD_CYCLES;
    send_random_set(6);
    send_random_set(TABLE_DEPTH + 2);
    drain();

    for (int p = 0; p < 4; p++) begin
      for (int m = 0; m < 2; m++) begin
        drain();
        write_policy(m[0]);
        tx_idle_pct  = (p == 1) ? 64 : (p == 3) ? 26 : 0;
        rx_stall_pct = (p == 2) ? 64 : (p == 3) ? 26 : 0;
        phase_items  = 0;
        while (phase_items < 14) send_random_set(1 + $urandom_range(9));
      end
    end

    s_tvalid <= 1'b0;
    while (sb.schedule_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Loaded %0d jobs in %0d sets under both policies, %0d scheduled jobs checked",
             sb.jobs_loaded, sb.sets_scheduled, sb.results_checked);
    $display("Included a table overflow set and a %0d-cycle output hold", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
